### sv/vector_distance_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef VECTOR_DISTANCE_UNIT_MACROS_SVH
`define VECTOR_DISTANCE_UNIT_MACROS_SVH

// Check on every clock edge, reset included.
`define VDU_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

// Check only while out of reset.
`define VDU_ASSERT_RUN(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`endif

### sv/vdu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vdu_pkg;

   // Vector geometry
   localparam int MaxDim    = 256;
   localparam int CoordBits = 16;
   localparam int CountBits = $clog2(MaxDim + 1);
   localparam int MagBits   = CoordBits + 1;
   localparam int TermBits  = 2 * CoordBits + 1;

   // Running sum and square root widths
   localparam int SumBits  = 40;
   localparam int RootBits = SumBits / 2;
   localparam int RemBits  = RootBits + 3;
   localparam int StepBits = $clog2(RootBits);

   // Job queue between accumulator and finisher
   localparam int QueueDepth     = 4;
   localparam int QueueAddrBits  = $clog2(QueueDepth);
   localparam int QueueCountBits = $clog2(QueueDepth + 1);

   // Metric register codes; the unused code acts as squared Euclidean
   localparam logic [1:0] MetricManhattan = 2'd0;
   localparam logic [1:0] MetricEuclid    = 2'd1;
   localparam logic [1:0] MetricSquared   = 2'd2;

   typedef struct packed {
      logic [SumBits-1:0] sum;
      logic               saturated;
      logic               take_root;
   } job_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_ROOT,
      BACK_WAIT
   } back_state_type;

endpackage

`default_nettype wire

### sv/vector_distance_unit.sv
// Vector distance unit: Manhattan, Euclidean or squared Euclidean distance.
// req_ channel: one coordinate pair per transfer, signed Q8.8 in tdata,
// tlast on the final pair of a vector. rsp_ channel: one distance per
// vector, 40 bits in tdata, saturation flag in tuser. csr_wr_en/csr_wr_data
// set the metric (0 Manhattan, 1 Euclidean, 2 or 3 squared); write it only
// while the block is idle.
// Throughput: one pair per cycle while the job queue has room. A term stage
// and the accumulator close a vector, which then enters a four-entry job
// queue; the finisher drains it. Manhattan and squared results pass from the
// queue to the output register; Euclidean results first run a bit-serial
// square root, one result bit per cycle (20 bits). The finisher takes one job
// at a time; short vectors stall req_tready once the queue fills.
// Reset (synchronous) clears the sum, element count, queue and metric; the
// block is ready in the cycle after reset. A stalled rsp_tready holds the
// result in the output register; pairs keep flowing until the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module vector_distance_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // coord_a [15:0], coord_b [31:16]
   input  wire logic [31:0] req_tdata,
   input  wire logic        req_tlast,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // distance_value [39:0]
   output      logic [39:0] rsp_tdata,
   // saturated [0]
   output      logic        rsp_tuser,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_wr_data
);

   logic [1:0]                          metric_mode_ff;
   logic                                take;
   logic                                push;
   vdu_pkg::job_type                    push_job;
   logic                                last_pending;
   logic                                pop;
   vdu_pkg::job_type                    head_job;
   logic                                not_empty;
   logic [vdu_pkg::QueueCountBits-1:0]  fill;

   // Hold the metric register
   always_ff @(posedge clock) begin
      if (reset) begin
         metric_mode_ff <= vdu_pkg::MetricManhattan;
      end else if (csr_wr_en) begin
         metric_mode_ff <= csr_wr_data;
      end
   end

   // Accept only while a closing vector is sure of a queue slot
   assign req_tready = (fill + vdu_pkg::QueueCountBits'(last_pending))
                       < vdu_pkg::QueueCountBits'(vdu_pkg::QueueDepth);
   assign take       = req_tvalid && req_tready;

   vdu_front u_front (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .coord_a      (req_tdata[vdu_pkg::CoordBits-1:0]),
      .coord_b      (req_tdata[2*vdu_pkg::CoordBits-1:vdu_pkg::CoordBits]),
      .last_element (req_tlast),
      .metric_mode  (metric_mode_ff),
      .push         (push),
      .push_job     (push_job),
      .last_pending (last_pending)
   );

   vdu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .head_job  (head_job),
      .not_empty (not_empty),
      .fill      (fill)
   );

   vdu_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_job      (head_job),
      .not_empty     (not_empty),
      .pop           (pop),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_value     (rsp_tdata),
      .out_saturated (rsp_tuser)
   );

endmodule

`default_nettype wire

### sv/vdu_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module vdu_queue (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               push,
   input  wire vdu_pkg::job_type                   push_job,
   input  wire logic                               pop,
   output      vdu_pkg::job_type                   head_job,
   output      logic                               not_empty,
   output      logic [vdu_pkg::QueueCountBits-1:0] fill
);

   vdu_pkg::job_type                   mem [vdu_pkg::QueueDepth];
   logic [vdu_pkg::QueueAddrBits-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [vdu_pkg::QueueAddrBits-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [vdu_pkg::QueueCountBits-1:0] count_ff, count_in;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Write storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

   assign head_job  = mem[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign fill      = count_ff;

endmodule

`default_nettype wire

### sv/vdu_front.sv
`timescale 1ns / 1ps
`default_nettype none

module vdu_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          take,
   input  wire logic [vdu_pkg::CoordBits-1:0] coord_a,
   input  wire logic [vdu_pkg::CoordBits-1:0] coord_b,
   input  wire logic                          last_element,
   input  wire logic [1:0]                    metric_mode,
   output      logic                          push,
   output      vdu_pkg::job_type              push_job,
   output      logic                          last_pending
);

   logic signed [vdu_pkg::MagBits-1:0]  diff;
   logic        [vdu_pkg::MagBits-1:0]  mag;
   logic        [2*vdu_pkg::MagBits-1:0] square;
   logic        [vdu_pkg::TermBits-1:0] term;

   logic                                a_valid_ff, a_valid_in;
   logic                                a_last_ff;
   logic                                a_root_ff;
   logic        [vdu_pkg::TermBits-1:0] a_term_ff;

   logic        [vdu_pkg::SumBits-1:0]   sum_ff, sum_in;
   logic        [vdu_pkg::CountBits-1:0] count_ff, count_in;
   logic                                 ovf_ff, ovf_in;
   logic        [vdu_pkg::SumBits:0]     sum_add;
   logic        [vdu_pkg::SumBits-1:0]   sum_step;
   logic                                 ovf_step;

   // Form the per-element term: magnitude or its square
   always_comb begin
      diff   = $signed({coord_a[vdu_pkg::CoordBits-1], coord_a})
             - $signed({coord_b[vdu_pkg::CoordBits-1], coord_b});
      mag    = diff[vdu_pkg::MagBits-1] ? vdu_pkg::MagBits'(-diff) : vdu_pkg::MagBits'(diff);
      square = mag * mag;
      if (metric_mode == vdu_pkg::MetricManhattan) begin
         term = vdu_pkg::TermBits'(mag);
      end else begin
         term = square[vdu_pkg::TermBits-1:0];
      end
   end

   assign a_valid_in = take;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   // Hold the term stage payload
   always_ff @(posedge clock) begin
      if (take) begin
         a_last_ff <= last_element;
         a_root_ff <= (metric_mode == vdu_pkg::MetricEuclid);
         a_term_ff <= term;
      end
   end

   // Accumulate with saturation and element limit
   always_comb begin
      sum_add  = {1'b0, sum_ff} + (vdu_pkg::SumBits + 1)'(a_term_ff);
      sum_step = sum_ff;
      ovf_step = ovf_ff;
      count_in = count_ff;
      if (count_ff >= vdu_pkg::CountBits'(vdu_pkg::MaxDim)) begin
         sum_step = '1;
         ovf_step = 1'b1;
      end else begin
         count_in = count_ff + 1'b1;
         if (sum_add[vdu_pkg::SumBits]) begin
            sum_step = '1;
            ovf_step = 1'b1;
         end else begin
            sum_step = sum_add[vdu_pkg::SumBits-1:0];
         end
      end

      push               = a_valid_ff && a_last_ff;
      push_job.sum       = sum_step;
      push_job.saturated = ovf_step;
      push_job.take_root = a_root_ff;

      sum_in = sum_ff;
      ovf_in = ovf_ff;
      if (!a_valid_ff) begin
         count_in = count_ff;
      end else if (a_last_ff) begin
         sum_in   = '0;
         ovf_in   = 1'b0;
         count_in = '0;
      end else begin
         sum_in = sum_step;
         ovf_in = ovf_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   assign last_pending = a_valid_ff && a_last_ff;

endmodule

`default_nettype wire

### sv/vdu_back.sv
`timescale 1ns / 1ps
`default_nettype none

module vdu_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire vdu_pkg::job_type            head_job,
   input  wire logic                        not_empty,
   output      logic                        pop,
   output      logic                        out_valid,
   input  wire logic                        out_ready,
   output      logic [vdu_pkg::SumBits-1:0] out_value,
   output      logic                        out_saturated
);

   vdu_pkg::back_state_type              state_ff, state_in;
   logic [vdu_pkg::RemBits-1:0]          rem_ff, rem_in;
   logic [vdu_pkg::RootBits-1:0]         root_ff, root_in;
   logic [vdu_pkg::SumBits-1:0]          rad_ff, rad_in;
   logic [vdu_pkg::StepBits-1:0]         step_ff, step_in;
   logic                                 sat_ff, sat_in;
   logic                                 out_valid_ff, out_valid_in;
   logic [vdu_pkg::SumBits-1:0]          out_value_ff, out_value_in;
   logic                                 out_sat_ff, out_sat_in;

   logic                                 out_free;
   logic [vdu_pkg::RemBits-1:0]          rem_shift;
   logic [vdu_pkg::RemBits-1:0]          trial;
   logic                                 fits;

   // One result bit per cycle of the square root
   always_comb begin
      out_free  = !out_valid_ff || out_ready;
      rem_shift = {rem_ff[vdu_pkg::RemBits-3:0], rad_ff[vdu_pkg::SumBits-1 -: 2]};
      trial     = vdu_pkg::RemBits'({root_ff, 2'b01});
      fits      = (rem_shift >= trial);
   end

   // Next state and outputs
   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      rad_in       = rad_ff;
      step_in      = step_ff;
      sat_in       = sat_ff;
      out_valid_in = out_valid_ff && !out_ready;
      out_value_in = out_value_ff;
      out_sat_in   = out_sat_ff;
      pop          = 1'b0;

      unique case (state_ff)
         vdu_pkg::BACK_IDLE: begin
            if (not_empty && out_free) begin
               pop = 1'b1;
               if (head_job.take_root) begin
                  rad_in   = head_job.sum;
                  rem_in   = '0;
                  root_in  = '0;
                  step_in  = vdu_pkg::StepBits'(vdu_pkg::RootBits - 1);
                  sat_in   = head_job.saturated;
                  state_in = vdu_pkg::BACK_ROOT;
               end else begin
                  out_valid_in = 1'b1;
                  out_value_in = head_job.sum;
                  out_sat_in   = head_job.saturated;
               end
            end
         end
         vdu_pkg::BACK_ROOT: begin
            rem_in  = fits ? (rem_shift - trial) : rem_shift;
            root_in = {root_ff[vdu_pkg::RootBits-2:0], fits};
            rad_in  = {rad_ff[vdu_pkg::SumBits-3:0], 2'b00};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = vdu_pkg::BACK_WAIT;
            end
         end
         vdu_pkg::BACK_WAIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_value_in = vdu_pkg::SumBits'(root_ff);
               out_sat_in   = sat_ff;
               state_in     = vdu_pkg::BACK_IDLE;
            end
         end
         default: begin
            state_in = vdu_pkg::BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vdu_pkg::BACK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Hold datapath registers
   always_ff @(posedge clock) begin
      rem_ff       <= rem_in;
      root_ff      <= root_in;
      rad_ff       <= rad_in;
      step_ff      <= step_in;
      sat_ff       <= sat_in;
      out_value_ff <= out_value_in;
      out_sat_ff   <= out_sat_in;
   end

   assign out_valid     = out_valid_ff;
   assign out_value     = out_value_ff;
   assign out_saturated = out_sat_ff;

endmodule

`default_nettype wire

### sv/vdu_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "vector_distance_unit_macros.svh"

module vdu_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tready,
   input  wire logic [39:0] rsp_tdata,
   input  wire logic        rsp_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready
);

   // Stalled result holds
   `VDU_ASSERT_RUN(rsp_hold_a, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")

   // Reset empties the pipe, so no result can surface until a new vector passes
   `VDU_ASSERT_ALWAYS(rsp_quiet_a, reset |=> !rsp_tvalid ##1 !rsp_tvalid ##1 !rsp_tvalid, "result too soon after reset")

   // Empty queue takes pairs right after reset
   `VDU_ASSERT_ALWAYS(req_ready_a, reset |=> req_tready, "not ready after reset")

   // No result is valid when reset is released
   `VDU_ASSERT_ALWAYS(rsp_reset_a, $past(reset) && !reset |-> !rsp_tvalid, "result leaked through reset")

endmodule

bind vector_distance_unit vdu_checker u_vdu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

`default_nettype wire
